[hdl/lzssd_pkg.sv]
`default_nettype none
package lzssd_pkg;

   localparam int unsigned OFFSET_W        = 12;
   localparam int unsigned LEN_W           = 5;
   localparam int unsigned MIN_MATCH       = 3;
   localparam int unsigned TOKENS_PER_FLAG = 8;
   localparam int unsigned CMD_DEPTH       = 4;

   // One unit of work for the copy engine: a literal (count is one) or a
   // window copy already trimmed to the bytes still owed.
   typedef struct packed {
      logic                literal;
      logic [OFFSET_W-1:0] value;      // literal byte in low bits, or window offset
      logic [LEN_W-1:0]    count;      // bytes to produce, 1 to 18
      logic                done;       // last byte of this command reaches output_size
   } cmd_type;

endpackage
`default_nettype wire

[hdl/lzssd_front.sv]
`default_nettype none
module lzssd_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_we,
   input  wire  [31:0]          csr_wdata,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [7:0]           req_tdata,   // in_byte
   input  wire                  req_tlast,   // end_of_input
   input  wire                  win_clearing,
   input  wire                  cmd_full,
   output logic                 cmd_push,
   output lzssd_pkg::cmd_type   cmd_data
);

   logic [31:0] size_ff,       size_in;
   logic [31:0] count_ff,      count_in;
   logic [7:0]  flags_ff,      flags_in;
   logic [3:0]  flags_left_ff, flags_left_in;
   logic        phase_ff,      phase_in;
   logic [7:0]  low_ff,        low_in;
   logic        fin_ff,        fin_in;

   logic                            accept;
   logic [32:0]                     diff;
   logic                            exhausted;
   logic [lzssd_pkg::LEN_W-1:0]     match_len;
   logic [lzssd_pkg::LEN_W-1:0]     eff_len;
   logic [lzssd_pkg::LEN_W-1:0]     push_len;
   logic                            push_done;

   assign req_tready = !win_clearing && !cmd_full;
   assign accept     = req_tvalid && req_tready;

   assign diff      = {1'b0, size_ff} - {1'b0, count_ff};
   assign exhausted = diff[32] || (diff[31:0] == 32'd0);
   assign match_len = {1'b0, req_tdata[3:0]} + lzssd_pkg::LEN_W'(lzssd_pkg::MIN_MATCH);
   // Trim a copy to the bytes still owed.
   assign eff_len   = (diff[31:0] < 32'(match_len)) ? diff[lzssd_pkg::LEN_W-1:0] : match_len;

   always_comb begin
      size_in       = csr_we ? csr_wdata : size_ff;
      count_in      = count_ff;
      flags_in      = flags_ff;
      flags_left_in = flags_left_ff;
      phase_in      = phase_ff;
      low_in        = low_ff;
      fin_in        = fin_ff;
      cmd_push      = 1'b0;
      push_len      = '0;
      push_done     = 1'b0;
      cmd_data.literal = 1'b0;
      cmd_data.value   = {req_tdata[7:4], low_ff};
      cmd_data.count   = eff_len;
      cmd_data.done    = 1'b0;

      if (accept) begin
         if (fin_ff || exhausted) begin
            fin_in = 1'b1;
         end else begin
            if (phase_ff) begin
               cmd_push = 1'b1;
               push_len = eff_len;
               phase_in = 1'b0;
            end else if (flags_left_ff == 4'd0) begin
               flags_in      = req_tdata;
               flags_left_in = 4'(lzssd_pkg::TOKENS_PER_FLAG);
            end else begin
               flags_in      = {1'b0, flags_ff[7:1]};
               flags_left_in = flags_left_ff - 4'd1;
               if (flags_ff[0]) begin
                  cmd_push         = 1'b1;
                  push_len         = lzssd_pkg::LEN_W'(1);
                  cmd_data.literal = 1'b1;
                  cmd_data.value   = {4'd0, req_tdata};
                  cmd_data.count   = lzssd_pkg::LEN_W'(1);
               end else begin
                  low_in   = req_tdata;
                  phase_in = 1'b1;
               end
            end
            push_done     = (diff[31:0] == 32'(push_len));
            cmd_data.done = cmd_push && push_done;
            count_in      = count_ff + 32'(push_len);
            fin_in        = req_tlast || (cmd_push && push_done);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff       <= '0;
         count_ff      <= '0;
         flags_ff      <= '0;
         flags_left_ff <= '0;
         phase_ff      <= 1'b0;
         low_ff        <= '0;
         fin_ff        <= 1'b0;
      end else begin
         size_ff       <= size_in;
         count_ff      <= count_in;
         flags_ff      <= flags_in;
         flags_left_ff <= flags_left_in;
         phase_ff      <= phase_in;
         low_ff        <= low_in;
         fin_ff        <= fin_in;
      end
   end

endmodule
`default_nettype wire

[hdl/lzssd_cmd_fifo.sv]
`default_nettype none
module lzssd_cmd_fifo (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  lzssd_pkg::cmd_type   push_data,
   output logic                 full,
   input  wire                  pop,
   output logic                 not_empty,
   output lzssd_pkg::cmd_type   pop_data
);

   localparam int unsigned PW = $clog2(lzssd_pkg::CMD_DEPTH);

   lzssd_pkg::cmd_type entry_ff [lzssd_pkg::CMD_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   fill_ff,   fill_in;

   assign full      = (fill_ff == (PW+1)'(lzssd_pkg::CMD_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

[hdl/lzssd_back.sv]
`default_nettype none
module lzssd_back #(
   parameter int unsigned WINDOW_BYTES = 4096
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  cmd_valid,
   input  lzssd_pkg::cmd_type   cmd_data,
   output logic                 cmd_pop,
   output logic                 win_clearing,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [7:0]           rsp_tdata,   // out_byte
   output logic                 rsp_tlast,   // last_of_run
   output logic                 rsp_tuser    // stream_done
);

   localparam int unsigned AW        = $clog2(WINDOW_BYTES);
   localparam int unsigned PTR_RESET = WINDOW_BYTES - 18;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type                   state_ff,     state_in;
   logic [AW-1:0]               clr_addr_ff,  clr_addr_in;
   logic [AW-1:0]               wp_ff,        wp_in;
   logic [AW-1:0]               src_ff,       src_in;
   logic [lzssd_pkg::LEN_W-1:0] left_ff,      left_in;
   logic                        lit_ff,       lit_in;
   logic [7:0]                  lit_byte_ff,  lit_byte_in;
   logic                        done_ff,      done_in;
   logic                        out_valid_ff, out_valid_in;
   logic [7:0]                  out_byte_ff,  out_byte_in;
   logic                        out_last_ff,  out_last_in;
   logic                        out_done_ff,  out_done_in;

   logic [7:0]    window_mem [WINDOW_BYTES];
   logic [7:0]    rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]    mem_wd;
   logic          mem_re;
   logic [7:0]    emit_byte;
   logic          out_free;
   logic          emit_fire;
   logic          final_byte;

   assign out_free     = !out_valid_ff || rsp_tready;
   assign emit_byte    = lit_ff ? lit_byte_ff : rd_data_ff;
   assign final_byte   = (left_ff == lzssd_pkg::LEN_W'(1));
   assign emit_fire    = (state_ff == ST_EMIT) && out_free;
   assign win_clearing = (state_ff == ST_CLEAR);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      wp_in        = wp_ff;
      src_in       = src_ff;
      left_in      = left_ff;
      lit_in       = lit_ff;
      lit_byte_in  = lit_byte_ff;
      done_in      = done_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      mem_we       = 1'b0;
      mem_wa       = wp_ff;
      mem_wd       = emit_byte;
      mem_re       = 1'b0;
      cmd_pop      = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_wa      = clr_addr_ff;
            mem_wd      = 8'd0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               src_in      = AW'(cmd_data.value);
               lit_byte_in = cmd_data.value[7:0];
               left_in     = cmd_data.count;
               lit_in      = cmd_data.literal;
               done_in     = cmd_data.done;
               state_in    = cmd_data.literal ? ST_EMIT : ST_READ;
            end
         end
         ST_READ: begin
            // The previous byte of this copy is already in the window here.
            mem_re   = 1'b1;
            src_in   = src_ff + AW'(1);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               mem_we       = 1'b1;
               wp_in        = wp_ff + AW'(1);
               out_valid_in = 1'b1;
               out_byte_in  = emit_byte;
               out_last_in  = final_byte;
               out_done_in  = done_ff && final_byte;
               left_in      = left_ff - lzssd_pkg::LEN_W'(1);
               state_in     = final_byte ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= window_mem[src_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         wp_ff        <= AW'(PTR_RESET);
         left_ff      <= '0;
         lit_ff       <= 1'b0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wp_ff        <= wp_in;
         left_ff      <= left_in;
         lit_ff       <= lit_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
      src_ff      <= src_in;
      lit_byte_ff <= lit_byte_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   a_no_output_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !out_valid_ff)
      else $error("result presented during window clear");

   a_copy_has_bytes_left: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_EMIT)) |-> (left_ff != '0))
      else $error("copy engine busy with no bytes left");

   a_write_pointer_steps: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> (wp_ff == $past(wp_ff) + AW'(1)))
      else $error("window write pointer did not advance by one");

   a_done_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_done_ff) |-> out_last_ff)
      else $error("stream end flagged on a byte that is not the last of its run");

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE) && cmd_valid)
      else $error("command taken while engine busy or queue empty");

endmodule
`default_nettype wire

[hdl/lzssd_top.sv]
`default_nettype none
// LZSS decompressor with a 4096-byte history window.
// req_*: one compressed byte per transaction (flag, literal or match byte);
//   req_tlast marks the final byte of the compressed stream.
// rsp_*: one decompressed byte per transaction; rsp_tlast marks the last
//   byte of one literal or copy, rsp_tuser marks the byte at which
//   the produced count reaches output_size.
// csr_*: write output_size while the block is idle.
// After reset the whole history is cleared to zero; req_tready
//   stays low during that pass.
// The parser takes one byte per cycle, while the queue is not full,
//   into a four-entry command queue. The copy engine takes a command
//   in its idle state, emits a literal directly, and for each copied
//   byte reads the window, then writes and outputs it. A literal's first
//   output passes the queue, idle and emit states and output register.
// A stalled receiver holds the output register; the engine and then the
//   queue fill, and req_tready drops once the queue is full.
module lzss_window_decompressor_top #(
   parameter int unsigned WINDOW_BYTES = 4096
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [31:0] csr_wdata,     // output_size
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,     // [7:0] in_byte
   input  wire         req_tlast,     // end_of_input
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,     // [7:0] out_byte
   output logic        rsp_tlast,     // last_of_run
   output logic        rsp_tuser      // [0] stream_done
);

   lzssd_pkg::cmd_type push_data;
   lzssd_pkg::cmd_type pop_data;
   logic               push;
   logic               pop;
   logic               full;
   logic               not_empty;
   logic               win_clearing;

   lzssd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .win_clearing (win_clearing),
      .cmd_full     (full),
      .cmd_push     (push),
      .cmd_data     (push_data)
   );

   lzssd_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   lzssd_back #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (not_empty),
      .cmd_data     (pop_data),
      .cmd_pop      (pop),
      .win_clearing (win_clearing),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule
`default_nettype wire
